// File: src/u8sd_pkg.sv
// Package for the UTF-8 stream decoder: word types and code point constants.
// Used by utf8_stream_decoder_top and by the u8sd_checker assertion module.
// No dependencies.
package u8sd_pkg;

    localparam int CP_W = 21;

    localparam logic [CP_W-1:0] REPL_CP    = 21'h00FFFD;
    localparam logic [CP_W-1:0] MAX_SCALAR = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO    = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI    = 21'h00DFFF;
    localparam logic [CP_W-1:0] MIN_LEN2   = 21'h000080;
    localparam logic [CP_W-1:0] MIN_LEN3   = 21'h000800;
    localparam logic [CP_W-1:0] MIN_LEN4   = 21'h010000;

    // Sequence lengths held in the expected-length and held-byte registers.
    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_ONE  = 3'd1;
    localparam logic [2:0] LEN_TWO  = 3'd2;
    localparam logic [2:0] LEN_THR  = 3'd3;
    localparam logic [2:0] LEN_FOUR = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       flush;
    } t_in_word;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            replaced;
        logic            last_of_run;
    } t_out_word;

    // Results of one input byte: rep_count replacements, then an optional tail.
    typedef struct packed {
        logic [2:0]      rep_count;
        logic            has_tail;
        logic [CP_W-1:0] tail_cp;
        logic            tail_rep;
        logic [2:0]      total;
    } t_run;

endpackage

// File: src/utf8_stream_decoder_top.sv
// Top level of the UTF-8 stream decoder: input register, decode logic,
// and a result stage giving each byte's results one word per unstalled cycle.
// Depends on u8sd_pkg.

// The decoder takes one byte word per cycle while o_stall is low and gives 0
// to 4 result words per byte. A byte waits in the input register until the
// result stage is free and is decoded there; its results are registered in
// the result stage. The output port carries one result word per cycle while
// i_stall is low, and that port sets the rate: a byte that gives k results
// holds the result stage until all k are taken (k = 0 or 1 for any well-formed
// text, so one byte per cycle is sustained without stalls). Errors and flush
// words give up to 4 replacements and stall the input until the last is taken.
module utf8_stream_decoder_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  u8sd_pkg::t_in_word  i_data,
    output logic                o_stall,
    output logic                o_valid,
    output u8sd_pkg::t_out_word o_data,
    input  logic                i_stall
);
    import u8sd_pkg::*;

    // Input register.
    logic     r_in_vld;
    t_in_word r_in;

    // Decoder state.
    logic [CP_W-1:0] r_pv, n_pv;
    logic [2:0]      r_exp, n_exp;
    logic [2:0]      r_held, n_held;

    // Result stage.
    logic       r_run_vld;
    t_run       r_run;
    logic [1:0] r_idx;

    // Start-of-sequence decode of the held byte.
    logic [CP_W-1:0] sb_pv;
    logic [2:0]      sb_exp;
    logic            sb_tail;
    logic [CP_W-1:0] sb_cp;
    logic            sb_rep;

    t_run            d_run;
    logic [CP_W-1:0] cont_pv;
    logic [2:0]      held_inc;
    logic [CP_W-1:0] min_val;
    logic            seq_bad;

    logic out_acc, run_last, run_free, fire, in_free;

    always_comb begin
        sb_pv   = '0;
        sb_exp  = LEN_NONE;
        sb_tail = 1'b1;
        sb_cp   = REPL_CP;
        sb_rep  = 1'b1;
        if (!r_in.data_byte[7]) begin
            sb_cp  = {13'd0, r_in.data_byte};
            sb_rep = 1'b0;
        end else if (r_in.data_byte[7:5] == 3'b110) begin
            sb_pv   = {16'd0, r_in.data_byte[4:0]};
            sb_exp  = LEN_TWO;
            sb_tail = 1'b0;
        end else if (r_in.data_byte[7:4] == 4'b1110) begin
            sb_pv   = {17'd0, r_in.data_byte[3:0]};
            sb_exp  = LEN_THR;
            sb_tail = 1'b0;
        end else if (r_in.data_byte[7:3] == 5'b11110) begin
            sb_pv   = {18'd0, r_in.data_byte[2:0]};
            sb_exp  = LEN_FOUR;
            sb_tail = 1'b0;
        end
    end

    assign cont_pv  = {r_pv[CP_W-7:0], r_in.data_byte[5:0]};
    assign held_inc = r_held + 3'd1;

    always_comb begin
        unique case (r_exp)
            LEN_TWO: min_val = MIN_LEN2;
            LEN_THR: min_val = MIN_LEN3;
            default: min_val = MIN_LEN4;
        endcase
    end

    assign seq_bad = (cont_pv < min_val) || (cont_pv > MAX_SCALAR)
                   || ((cont_pv >= SURR_LO) && (cont_pv <= SURR_HI));

    always_comb begin
        d_run           = '0;
        d_run.tail_cp   = REPL_CP;
        d_run.tail_rep  = 1'b1;
        n_pv            = r_pv;
        n_exp           = r_exp;
        n_held          = r_held;
        if (r_in.flush) begin
            d_run.rep_count = (r_exp != LEN_NONE) ? r_held : 3'd0;
            n_pv   = '0;
            n_exp  = LEN_NONE;
            n_held = 3'd0;
        end else if (r_exp == LEN_NONE) begin
            d_run.has_tail = sb_tail;
            d_run.tail_cp  = sb_cp;
            d_run.tail_rep = sb_rep;
            n_pv   = sb_pv;
            n_exp  = sb_exp;
            n_held = sb_tail ? 3'd0 : LEN_ONE;
        end else if (r_in.data_byte[7:6] == 2'b10) begin
            if (held_inc >= r_exp) begin
                if (seq_bad) begin
                    d_run.rep_count = r_exp;
                end else begin
                    d_run.has_tail = 1'b1;
                    d_run.tail_cp  = cont_pv;
                    d_run.tail_rep = 1'b0;
                end
                n_pv   = '0;
                n_exp  = LEN_NONE;
                n_held = 3'd0;
            end else begin
                n_pv   = cont_pv;
                n_held = held_inc;
            end
        end else begin
            // The held bytes are replaced, then this byte starts over as a lead.
            d_run.rep_count = r_held;
            d_run.has_tail  = sb_tail;
            d_run.tail_cp   = sb_cp;
            d_run.tail_rep  = sb_rep;
            n_pv   = sb_pv;
            n_exp  = sb_exp;
            n_held = sb_tail ? 3'd0 : LEN_ONE;
        end
        d_run.total = d_run.rep_count + {2'b00, d_run.has_tail};
    end

    assign out_acc  = r_run_vld && !i_stall;
    assign run_last = ({1'b0, r_idx} + 3'd1) == r_run.total;
    assign run_free = !r_run_vld || (out_acc && run_last);
    assign fire     = r_in_vld && run_free;
    assign in_free  = !r_in_vld || run_free;
    assign o_stall  = !in_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_free) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_free) begin
            r_in <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv   <= '0;
            r_exp  <= LEN_NONE;
            r_held <= 3'd0;
        end else if (fire) begin
            r_pv   <= n_pv;
            r_exp  <= n_exp;
            r_held <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_vld <= 1'b0;
            r_idx     <= 2'd0;
        end else if (fire && (d_run.total != 3'd0)) begin
            r_run_vld <= 1'b1;
            r_idx     <= 2'd0;
        end else if (run_free) begin
            r_run_vld <= 1'b0;
            r_idx     <= 2'd0;
        end else if (out_acc) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && (d_run.total != 3'd0)) begin
            r_run <= d_run;
        end
    end

    always_comb begin
        o_valid = r_run_vld;
        if ({1'b0, r_idx} < r_run.rep_count) begin
            o_data.code_point = REPL_CP;
            o_data.replaced   = 1'b1;
        end else begin
            o_data.code_point = r_run.tail_cp;
            o_data.replaced   = r_run.tail_rep;
        end
        o_data.last_of_run = run_last;
    end

endmodule

// File: src/u8sd_checker.sv
// Assertion checker for the UTF-8 stream decoder, watching the top-level ports.
// Depends on u8sd_pkg; bound to utf8_stream_decoder_top at the end of this file.
module u8sd_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input u8sd_pkg::t_in_word  i_data,
    input logic                o_stall,
    input logic                o_valid,
    input u8sd_pkg::t_out_word o_data,
    input logic                i_stall
);
    import u8sd_pkg::*;

    // A stalled input word holds.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_stall) |=> (i_valid && $stable(i_data)))
        else $error("input word changed while stalled");

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data)))
        else $error("result word changed while stalled");

    // Reset empties the result stage.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result word valid right after reset");

    // A run that is not finished keeps going in the next cycle.
    a_run_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_data.last_of_run) |=> o_valid)
        else $error("run of results ended without a last word");

    // Replacements carry U+FFFD, decoded values are Unicode scalar values.
    a_cp_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.replaced ? (o_data.code_point == REPL_CP)
                     : ((o_data.code_point <= MAX_SCALAR)
                        && ((o_data.code_point < SURR_LO)
                            || (o_data.code_point > SURR_HI)))))
        else $error("illegal code point on result word");

endmodule

bind utf8_stream_decoder_top u8sd_checker u_u8sd_checker (.*);

// File: tb/sv/utf8_stream_decoder_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for utf8_stream_decoder_top: a byte driver, a result monitor and a
// scoreboard that decodes each accepted byte word on its own and compares result words.
// Depends on u8sd_pkg and utf8_stream_decoder_top.
module utf8_stream_decoder_top_tb;
    import u8sd_pkg::*;

    typedef struct packed {
        t_in_word w;
        logic     drain;
    } t_byte_item;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    t_in_word  i_data = '0;
    logic      o_stall;
    logic      o_valid;
    t_out_word o_data;
    logic      i_stall = 1'b0;

    t_byte_item byte_q[$];
    t_out_word  cp_expect_q[$];
    t_out_word  byte_results_q[$];

    // Decoder state as the scoreboard sees it.
    logic [CP_W-1:0] seq_value;
    logic [2:0]      seq_len;
    logic [2:0]      seq_held;

    logic [7:0] enc [0:3];
    bit         in_taken = 1'b0;
    int         bytes_taken = 0;
    int         total_bytes = 0;
    int         mismatches = 0;

    utf8_stream_decoder_top uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .i_data (i_data),
        .o_stall(o_stall),
        .o_valid(o_valid),
        .o_data (o_data),
        .i_stall(i_stall)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ---------------- scoreboard decoder ----------------

    task automatic drop_sequence();
        seq_value = '0;
        seq_len = LEN_NONE;
        seq_held = '0;
    endtask

    task automatic push_cp(input logic [CP_W-1:0] cp, input logic rep);
        t_out_word r;
        r.code_point = cp;
        r.replaced = rep;
        r.last_of_run = 1'b0;
        byte_results_q.push_back(r);
    endtask

    task automatic push_repl(input int count);
        for (int i = 0; i < count; i++) begin
            push_cp(REPL_CP, 1'b1);
        end
    endtask

    task automatic start_lead(input logic [7:0] b);
        if (b[7] == 1'b0) begin
            push_cp(CP_W'(b), 1'b0);
        end else if (b[7:5] == 3'b110) begin
            seq_value = CP_W'(b[4:0]);
            seq_len = LEN_TWO;
            seq_held = LEN_ONE;
        end else if (b[7:4] == 4'b1110) begin
            seq_value = CP_W'(b[3:0]);
            seq_len = LEN_THR;
            seq_held = LEN_ONE;
        end else if (b[7:3] == 5'b11110) begin
            seq_value = CP_W'(b[2:0]);
            seq_len = LEN_FOUR;
            seq_held = LEN_ONE;
        end else begin
            push_cp(REPL_CP, 1'b1);
        end
    endtask

    task automatic decode_byte(input t_in_word w);
        logic [CP_W-1:0] min_cp;
        t_out_word       r;
        byte_results_q.delete();
        if (w.flush) begin
            if (seq_len != LEN_NONE) push_repl(int'(seq_held));
            drop_sequence();
        end else if (seq_len == LEN_NONE) begin
            start_lead(w.data_byte);
        end else if (w.data_byte[7:6] == 2'b10) begin
            seq_value = {seq_value[CP_W-7:0], w.data_byte[5:0]};
            seq_held = seq_held + 3'd1;
            if (seq_held >= seq_len) begin
                min_cp = (seq_len == LEN_TWO) ? MIN_LEN2 :
                         (seq_len == LEN_THR) ? MIN_LEN3 : MIN_LEN4;
                if (seq_value < min_cp || seq_value > MAX_SCALAR ||
                    (seq_value >= SURR_LO && seq_value <= SURR_HI)) begin
                    push_repl(int'(seq_len));
                end else begin
                    push_cp(seq_value, 1'b0);
                end
                drop_sequence();
            end
        end else begin
            // The broken sequence is replaced, then this byte starts over as a lead.
            push_repl(int'(seq_held));
            drop_sequence();
            start_lead(w.data_byte);
        end
        for (int i = 0; i < byte_results_q.size(); i++) begin
            r = byte_results_q[i];
            r.last_of_run = (i == byte_results_q.size() - 1);
            cp_expect_q.push_back(r);
        end
    endtask

    // ---------------- stimulus helpers ----------------

    task automatic add_byte(input logic [7:0] b, input logic fl = 1'b0,
                            input logic drain = 1'b0);
        t_byte_item it;
        it.w.data_byte = b;
        it.w.flush = fl;
        it.drain = drain;
        byte_q.push_back(it);
    endtask

    task automatic add_flush();
        add_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Encodes cp in n bytes without any range check, so overlong forms come out too.
    function automatic void encode_cp(input logic [CP_W-1:0] cp, input int n);
        case (n)
            1: enc[0] = {1'b0, cp[6:0]};
            2: begin
                enc[0] = {3'b110, cp[10:6]};
                enc[1] = {2'b10, cp[5:0]};
            end
            3: begin
                enc[0] = {4'b1110, cp[15:12]};
                enc[1] = {2'b10, cp[11:6]};
                enc[2] = {2'b10, cp[5:0]};
            end
            default: begin
                enc[0] = {5'b11110, cp[20:18]};
                enc[1] = {2'b10, cp[17:12]};
                enc[2] = {2'b10, cp[11:6]};
                enc[3] = {2'b10, cp[5:0]};
            end
        endcase
    endfunction

    task automatic add_encoded(input int count);
        for (int i = 0; i < count; i++) add_byte(enc[i]);
    endtask

    function automatic int sender_idle_pct();
        if (bytes_taken < total_bytes / 3) return 17;
        if (bytes_taken < 2 * total_bytes / 3) return 57;
        return 0;
    endfunction

    function automatic int receiver_stall_pct();
        if (bytes_taken < total_bytes / 3) return 57;
        if (bytes_taken < 2 * total_bytes / 3) return 17;
        return 0;
    endfunction

    // ---------------- driver ----------------

    always @(negedge i_clk) begin
        if (i_rst_n && !(i_valid && !in_taken)) begin
            if (byte_q.size() != 0 && !(byte_q[0].drain && cp_expect_q.size() != 0) &&
                $urandom_range(0, 99) >= sender_idle_pct()) begin
                i_data <= byte_q.pop_front().w;
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) i_stall <= ($urandom_range(0, 99) < receiver_stall_pct());
    end

    // ---------------- monitor ----------------

    always @(posedge i_clk) begin
        t_out_word want;
        in_taken = i_rst_n && i_valid && !o_stall;
        if (in_taken) begin
            decode_byte(i_data);
            bytes_taken++;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (cp_expect_q.size() == 0) begin
                $display("%0t: unexpected word code_point=%h replaced=%b last_of_run=%b",
                         $time, o_data.code_point, o_data.replaced, o_data.last_of_run);
                mismatches++;
            end else begin
                want = cp_expect_q.pop_front();
                if (o_data.code_point !== want.code_point) begin
                    $display("%0t: code_point expected %h actual %h",
                             $time, want.code_point, o_data.code_point);
                    mismatches++;
                end
                if (o_data.replaced !== want.replaced) begin
                    $display("%0t: replaced expected %b actual %b",
                             $time, want.replaced, o_data.replaced);
                    mismatches++;
                end
                if (o_data.last_of_run !== want.last_of_run) begin
                    $display("%0t: last_of_run expected %b actual %b",
                             $time, want.last_of_run, o_data.last_of_run);
                    mismatches++;
                end
            end
        end
    end

    // ---------------- stimulus and end of run ----------------

    initial begin
        int              sel;
        int              n;
        int              directed_count;
        logic [CP_W-1:0] cp;

        drop_sequence();

        // ASCII extremes and invalid leads at both ends of their range.
        add_byte(8'h00); add_byte(8'h7F); add_byte(8'h80); add_byte(8'hFF);
        // Overlong two-byte form.
        add_byte(8'hC0); add_byte(8'h80);
        // Largest scalar value.
        add_byte(8'hF4); add_byte(8'h8F); add_byte(8'hBF); add_byte(8'hBF);
        // Surrogate.
        add_byte(8'hED); add_byte(8'hA0); add_byte(8'h80);
        // A lead above the scalar range.
        add_byte(8'hF5); add_byte(8'h80); add_byte(8'h80); add_byte(8'h80);
        // Three bytes held, then an invalid lead: four replacements from one word.
        add_byte(8'hF0); add_byte(8'h9F); add_byte(8'h98); add_byte(8'hFF);
        // Flush with two bytes pending, then a flush with nothing pending.
        add_byte(8'hE2); add_byte(8'h82); add_flush(); add_flush();
        directed_count = byte_q.size();

        while (byte_q.size() - directed_count < 105) begin
            sel = $urandom_range(0, 99);
            if (sel < 55) begin
                n = $urandom_range(1, 4);
                case (n)
                    1: cp = CP_W'($urandom_range(0, 'h7F));
                    2: cp = CP_W'($urandom_range('h80, 'h7FF));
                    3: cp = CP_W'($urandom_range('h800, 'hFFFF));
                    default: cp = CP_W'($urandom_range('h10000, 'h10FFFF));
                endcase
                encode_cp(cp, n);
                add_encoded(n);
            end else if (sel < 68) begin
                // Overlong, surrogate or out of range.
                n = $urandom_range(2, 4);
                if (n == 3 && $urandom_range(0, 1))
                    cp = CP_W'($urandom_range('hD800, 'hDFFF));
                else if (n == 4 && $urandom_range(0, 1))
                    cp = CP_W'($urandom_range('h110000, 'h1FFFFF));
                else if (n == 2) cp = CP_W'($urandom_range(0, 'h7F));
                else if (n == 3) cp = CP_W'($urandom_range(0, 'h7FF));
                else cp = CP_W'($urandom_range(0, 'hFFFF));
                encode_cp(cp, n);
                add_encoded(n);
            end else if (sel < 82) begin
                // Truncated sequence, followed by a flush or by a random byte.
                n = $urandom_range(2, 4);
                encode_cp(CP_W'($urandom_range('h80, 'h10FFFF)), n);
                add_encoded($urandom_range(1, n - 1));
                if ($urandom_range(0, 1)) add_flush();
                else add_byte(8'($urandom_range(0, 255)));
            end else if (sel < 88) begin
                add_flush();
            end else begin
                add_byte(8'($urandom_range(0, 255)));
            end
        end
        // The first random word waits until every result so far has come out.
        byte_q[directed_count].drain = 1'b1;
        total_bytes = byte_q.size();

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (bytes_taken < total_bytes) @(negedge i_clk);
        while (cp_expect_q.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);

        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
